@@ rtl/core/bva_pkg.sv @@
// ----------------------------------------------------------------------------
// bva_pkg
// Shared widths, constants and types for the battery voltage averager.
// ----------------------------------------------------------------------------
package bva_pkg;

    // history ring depth, a power of two so the mean is a plain shift
    localparam int HISTORY_DEPTH = 8;
    localparam int SAMPLE_BITS   = 10;

    localparam int IDX_BITS   = $clog2(HISTORY_DEPTH);
    localparam int SUM_BITS   = SAMPLE_BITS + IDX_BITS;
    localparam int VALUE_BITS = SAMPLE_BITS + 1;
    localparam int LEVEL_BITS = 7;
    localparam int PROD_BITS  = SAMPLE_BITS + LEVEL_BITS;
    localparam int CNT_BITS   = $clog2(LEVEL_BITS);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = {SAMPLE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0]  PLUGGED_CODE = VALUE_BITS'(1) << SAMPLE_BITS;
    localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX    = LEVEL_BITS'(100);

    // configuration register indexes
    localparam logic [2:0] REG_EMPTY    = 3'd0;
    localparam logic [2:0] REG_FULL     = 3'd1;
    localparam logic [2:0] REG_LOW      = 3'd2;
    localparam logic [2:0] REG_CRITICAL = 3'd3;
    localparam logic [2:0] REG_GLITCH   = 3'd4;

    localparam logic [SAMPLE_BITS-1:0] EMPTY_RESET    = SAMPLE_BITS'(768);
    localparam logic [SAMPLE_BITS-1:0] FULL_RESET     = SAMPLE_BITS'(880);
    localparam logic [SAMPLE_BITS-1:0] LOW_RESET      = SAMPLE_BITS'(779);
    localparam logic [SAMPLE_BITS-1:0] CRITICAL_RESET = SAMPLE_BITS'(773);
    localparam logic [SAMPLE_BITS-1:0] GLITCH_RESET   = SAMPLE_BITS'(256);

    // low status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_LOW      = 2'd1;
    localparam logic [1:0] STATUS_CRITICAL = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

@@ rtl/core/battery_voltage_averager.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_averager
// Eight-slot moving average of battery readings with charge level and
// low-battery status.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with the reading, cable flag and
// fill request; a beat is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with filtered value, charging
// flag, level percent and low status; one result beat per input beat.
// Config channel: i_cfg_valid / o_cfg_ready, index 0..4 selects empty, full,
// low, critical and glitch levels; other indexes are dropped.
// Order: the history is updated at the accepting edge unless the cable is
// connected without a fill request, then state S_MEAN forms the mean (or
// the plugged code) and S_LEVEL compares and starts the level division. The
// divider works out one quotient bit per step and runs only when the value
// lies strictly between empty and full. The result waits in S_HOLD and goes
// from there to the output register. Input is stalled from acceptance until
// the result is handed to the output register, so a new reading is taken
// only once the last one is through.
// A stalled output holds its result; the next item may be accepted and
// worked on meanwhile, and waits before the output register until free.
// Reset clears the history, sum, index and levels to their defaults.
// ----------------------------------------------------------------------------
module battery_voltage_averager import bva_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_adc_sample,
    input  logic                   i_cable_connected,
    input  logic                   i_fill,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_BITS-1:0]  o_filtered_value,
    output logic                   o_charging,
    output logic [LEVEL_BITS-1:0]  o_level_percent,
    output logic [1:0]             o_low_status,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_LEVEL,
        S_DIV,
        S_HOLD
    } t_state;

    t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_empty, r_full, r_low, r_critical, r_glitch;
    logic                   r_cable, n_cable;
    logic [VALUE_BITS-1:0]  r_value, n_value;
    logic [LEVEL_BITS-1:0]  r_level, n_level;
    logic [1:0]             r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]  r_out_value, n_out_value;
    logic [LEVEL_BITS-1:0]  r_out_level, n_out_level;
    logic [1:0]             r_out_status, n_out_status;

    logic                   in_beat;
    logic                   out_free;
    logic                   div_start;
    logic [SAMPLE_BITS-1:0] diff;
    logic [PROD_BITS-1:0]   dividend;
    logic [SAMPLE_BITS-1:0] divisor;
    logic [SUM_BITS-1:0]    hist_sum;
    t_div_status            div_status;
    logic [LEVEL_BITS-1:0]  quotient;

    assign in_beat     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // value lies in (empty, full) whenever the divider is started
    assign diff     = r_value[SAMPLE_BITS-1:0] - r_empty;
    assign dividend = PROD_BITS'(diff) * PROD_BITS'(LEVEL_MAX);
    assign divisor  = r_full - r_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty    <= EMPTY_RESET;
            r_full     <= FULL_RESET;
            r_low      <= LOW_RESET;
            r_critical <= CRITICAL_RESET;
            r_glitch   <= GLITCH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_EMPTY:    r_empty    <= i_cfg_data;
                REG_FULL:     r_full     <= i_cfg_data;
                REG_LOW:      r_low      <= i_cfg_data;
                REG_CRITICAL: r_critical <= i_cfg_data;
                REG_GLITCH:   r_glitch   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bva_history u_history (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_write        (in_beat && (i_fill || !i_cable_connected)),
        .i_fill         (i_fill),
        .i_sample       (i_adc_sample),
        .i_glitch_limit (r_glitch),
        .o_sum          (hist_sum)
    );

    bva_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_status   (div_status),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state      = r_state;
        n_cable      = r_cable;
        n_value      = r_value;
        n_level      = r_level;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_value  = r_out_value;
        n_out_level  = r_out_level;
        n_out_status = r_out_status;
        div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_cable = i_cable_connected;
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                n_value = r_cable ? PLUGGED_CODE
                                  : VALUE_BITS'(hist_sum / HISTORY_DEPTH);
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                if (r_value <= {1'b0, r_critical}) begin
                    n_status = STATUS_CRITICAL;
                end else if (r_value <= {1'b0, r_low}) begin
                    n_status = STATUS_LOW;
                end else begin
                    n_status = STATUS_OK;
                end
                if (r_value <= {1'b0, r_empty}) begin
                    n_level = '0;
                    n_state = S_HOLD;
                end else if (r_value >= {1'b0, r_full}) begin
                    n_level = LEVEL_MAX;
                    n_state = S_HOLD;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    n_level = quotient;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_value;
                    n_out_level  = r_level;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cable      <= n_cable;
        r_value      <= n_value;
        r_level      <= n_level;
        r_status     <= n_status;
        r_out_value  <= n_out_value;
        r_out_level  <= n_out_level;
        r_out_status <= n_out_status;
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_charging       = (r_out_value == PLUGGED_CODE);
    assign o_level_percent  = r_out_level;
    assign o_low_status     = r_out_status;

endmodule

@@ rtl/core/bva_history.sv @@
// ----------------------------------------------------------------------------
// bva_history
// Sample ring with running sum; fill loads every slot, a normal beat
// replaces the oldest slot after glitch substitution.
// ----------------------------------------------------------------------------
module bva_history import bva_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_write,
    input  logic                   i_fill,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_glitch_limit,
    output logic [SUM_BITS-1:0]    o_sum
);

    logic [SAMPLE_BITS-1:0] r_hist [HISTORY_DEPTH];
    logic [IDX_BITS-1:0]    r_idx;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] n_slot;
    logic [SUM_BITS-1:0]    n_sum;
    logic [IDX_BITS-1:0]    n_idx;

    always_comb begin
        n_slot = (i_sample < i_glitch_limit) ? SAMPLE_MAX : i_sample;
        n_sum  = r_sum - SUM_BITS'(r_hist[r_idx]) + SUM_BITS'(n_slot);
        n_idx  = (r_idx == IDX_BITS'(HISTORY_DEPTH - 1)) ? '0 : r_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_idx <= '0;
            r_sum <= '0;
        end else if (i_write) begin
            if (i_fill) begin
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    r_hist[k] <= i_sample;
                end
                r_idx <= '0;
                r_sum <= SUM_BITS'(i_sample) * SUM_BITS'(HISTORY_DEPTH);
            end else begin
                r_hist[r_idx] <= n_slot;
                r_idx         <= n_idx;
                r_sum         <= n_sum;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

@@ rtl/core/bva_divider.sv @@
// ----------------------------------------------------------------------------
// bva_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit LEVEL_BITS, so only that many steps are run.
// ----------------------------------------------------------------------------
module bva_divider import bva_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PROD_BITS-1:0]   i_dividend,
    input  logic [SAMPLE_BITS-1:0] i_divisor,
    output t_div_status            o_status,
    output logic [LEVEL_BITS-1:0]  o_quotient
);

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [LEVEL_BITS-1:0]  r_low;
    logic [SAMPLE_BITS-1:0] r_div;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [SAMPLE_BITS:0]   n_trial;
    logic                   n_ge;

    always_comb begin
        n_trial = {r_rem, r_low[LEVEL_BITS-1]};
        n_ge    = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(LEVEL_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: upper dividend bits start below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_BITS-1:LEVEL_BITS];
            r_low <= i_dividend[LEVEL_BITS-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? SAMPLE_BITS'(n_trial - {1'b0, r_div})
                          : n_trial[SAMPLE_BITS-1:0];
            r_low <= {r_low[LEVEL_BITS-2:0], n_ge};
        end
    end

    assign o_status   = '{busy: r_busy, done: r_done};
    assign o_quotient = r_low;

endmodule

@@ rtl/core/bva_checker.sv @@
// ----------------------------------------------------------------------------
// bva_checker
// Port-level checks for the battery voltage averager, bound to the top.
// ----------------------------------------------------------------------------
module bva_checker import bva_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  logic [VALUE_BITS-1:0]  o_filtered_value,
    input  logic                   o_charging,
    input  logic [LEVEL_BITS-1:0]  o_level_percent,
    input  logic [1:0]             o_low_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_filtered_value))
        else $error("stalled result beat dropped or changed");

    a_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charging == (o_filtered_value == PLUGGED_CODE)))
        else $error("charging flag disagrees with filtered value");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_level_percent <= LEVEL_MAX)
        else $error("level percent above 100");

    a_plugged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_charging |->
            o_level_percent == LEVEL_MAX && o_low_status == STATUS_OK)
        else $error("plugged result without full level and ok status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_low_status == STATUS_OK || o_low_status == STATUS_LOW
            || o_low_status == STATUS_CRITICAL)
        else $error("undefined low status code");

endmodule

bind battery_voltage_averager bva_checker u_bva_checker (.*);
